### sv/brf_pkg.sv
// shared constants, types and helpers of the broadcast ring fifo
package brf_pkg;

    localparam int DEPTH      = 16;
    localparam int READERS    = 4;
    localparam int DATA_WIDTH = 32;

    // ring index, entry count and ring size widths
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = IDX_W;
    localparam int SIZE_W = $clog2(DEPTH + 1);

    // external field widths
    localparam int CFG_W    = 5;
    localparam int WORD_W   = 32;
    localparam int RID_W    = 2;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 4;

    // compare width wide enough for the register and the ring size
    localparam int CMP_W = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;

    localparam logic [READERS-1:0] ALL_READERS = {READERS{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_KEPT    = 3'd3,
        ST_RETIRED = 3'd4
    } status_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } op_t;

    // slot write request from control to storage
    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      addr;
        logic [DATA_WIDTH-1:0] data;
    } wr_req_t;

    // clamp a ring size register value into 2..DEPTH
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] ext;
        logic [CMP_W-1:0] res;
        begin
            ext = CMP_W'(v);
            res = ext;
            if (ext < CMP_W'(2))
            begin
                res = CMP_W'(2);
            end
            if (ext > CMP_W'(DEPTH))
            begin
                res = CMP_W'(DEPTH);
            end
            return SIZE_W'(res);
        end
    endfunction

    // step a ring index, wrapping at the ring size
    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [SIZE_W-1:0] size);
        logic [SIZE_W:0] nxt;
        begin
            nxt = (SIZE_W + 1)'(idx) + (SIZE_W + 1)'(1);
            if (nxt >= (SIZE_W + 1)'(size))
            begin
                return '0;
            end
            return IDX_W'(nxt);
        end
    endfunction

endpackage

### sv/brf_store.sv
// slot storage: one write port, one read port at the head index
module brf_store
(
    input  logic                               clk,
    input  brf_pkg::wr_req_t                   wr,
    input  logic [brf_pkg::IDX_W-1:0]          rd_addr,
    output logic [brf_pkg::DATA_WIDTH-1:0]     rd_data
);

    logic [brf_pkg::DATA_WIDTH-1:0] slot_reg [brf_pkg::DEPTH];

    // slot write
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            slot_reg[wr.addr] <= wr.data;
        end
    end

    // head read
    assign rd_data = slot_reg[rd_addr];

endmodule

### sv/brf_ctrl.sv
// ring pointers, entry count, reader mask and per-operation result
module brf_ctrl
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [brf_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                               op_en,
    input  logic                               op_func,
    input  logic [brf_pkg::DATA_WIDTH-1:0]     op_word,
    input  logic [brf_pkg::RID_W-1:0]          op_reader,
    input  logic [brf_pkg::DATA_WIDTH-1:0]     rd_data,
    output brf_pkg::wr_req_t                   wr,
    output logic [brf_pkg::IDX_W-1:0]          rd_addr,
    output brf_pkg::status_t                   res_status,
    output logic [brf_pkg::WORD_W-1:0]         res_head,
    output logic [brf_pkg::OCC_W-1:0]          res_occ
);

    logic [brf_pkg::SIZE_W-1:0]  size_reg;
    logic [brf_pkg::IDX_W-1:0]   wr_idx_reg,  wr_idx_next;
    logic [brf_pkg::IDX_W-1:0]   rd_idx_reg,  rd_idx_next;
    logic [brf_pkg::CNT_W-1:0]   count_reg,   count_next;
    logic [brf_pkg::READERS-1:0] mask_reg,    mask_next;
    logic [brf_pkg::READERS-1:0] mask_marked;
    logic                        is_full;

    assign rd_addr = rd_idx_reg;
    assign is_full = (brf_pkg::SIZE_W'(count_reg) + brf_pkg::SIZE_W'(1)) >= size_reg;

    // mark the reader when its id is in range
    always_comb
    begin
        mask_marked = mask_reg;
        if (32'(op_reader) < brf_pkg::READERS)
        begin
            mask_marked = mask_reg | (brf_pkg::READERS'(1) << op_reader);
        end
    end

    // operation decode and next state
    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        mask_next   = mask_reg;
        wr.en       = 1'b0;
        wr.addr     = wr_idx_reg;
        wr.data     = op_word;
        res_status  = brf_pkg::ST_EMPTY;
        res_head    = '0;
        if (op_func == brf_pkg::OP_PUSH)
        begin
            if (is_full)
            begin
                res_status = brf_pkg::ST_FULL;
            end
            else
            begin
                wr.en       = op_en;
                wr_idx_next = brf_pkg::advance(wr_idx_reg, size_reg);
                count_next  = count_reg + brf_pkg::CNT_W'(1);
                res_status  = brf_pkg::ST_PUSHED;
            end
        end
        else if (count_reg != '0)
        begin
            res_head = brf_pkg::WORD_W'(rd_data);
            if (mask_marked == brf_pkg::ALL_READERS)
            begin
                rd_idx_next = brf_pkg::advance(rd_idx_reg, size_reg);
                count_next  = count_reg - brf_pkg::CNT_W'(1);
                mask_next   = '0;
                res_status  = brf_pkg::ST_RETIRED;
            end
            else
            begin
                mask_next  = mask_marked;
                res_status = brf_pkg::ST_KEPT;
            end
        end
        res_occ = brf_pkg::OCC_W'(count_next);
    end

    // state registers; a size write also empties the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= brf_pkg::clamp_size(brf_pkg::CFG_W'(16));
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
            mask_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            size_reg   <= brf_pkg::clamp_size(cfg_wr_data);
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
            mask_reg   <= '0;
        end
        else if (op_en)
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
            mask_reg   <= mask_next;
        end
    end

endmodule

### sv/broadcast_ring_fifo.sv
// top level: input register, ring control and storage, result register
// an accepted transfer is held in the input register until its result is registered
// throughput: one operation per cycle when not stalled; the ring state is updated by the
//   operation in the input register in one pass, so back-to-back operations see fresh state
// reset: pointers, count and reader mask clear, ring size returns to 16 slots;
//   slot contents are not cleared
module broadcast_ring_fifo
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [brf_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               func,
    input  logic [brf_pkg::WORD_W-1:0]         push_word,
    input  logic [brf_pkg::RID_W-1:0]          reader_id,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [brf_pkg::STATUS_W-1:0]       status,
    output logic [brf_pkg::WORD_W-1:0]         head_word,
    output logic [brf_pkg::OCC_W-1:0]          occupancy
);

    logic                           s1_valid_reg;
    logic                           s1_func_reg;
    logic [brf_pkg::DATA_WIDTH-1:0] s1_word_reg;
    logic [brf_pkg::RID_W-1:0]      s1_reader_reg;
    logic                           s1_go;
    logic                           in_take;

    brf_pkg::wr_req_t               wr;
    logic [brf_pkg::IDX_W-1:0]      rd_addr;
    logic [brf_pkg::DATA_WIDTH-1:0] rd_data;
    brf_pkg::status_t               res_status;
    logic [brf_pkg::WORD_W-1:0]     res_head;
    logic [brf_pkg::OCC_W-1:0]      res_occ;

    logic [brf_pkg::STATUS_W-1:0]   status_reg;
    logic [brf_pkg::WORD_W-1:0]     head_reg;
    logic [brf_pkg::OCC_W-1:0]      occ_reg;
    logic                           out_valid_reg, out_valid_next;

    // flow control between the two registers
    assign s1_go    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take || s1_go)
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg   <= func;
            s1_word_reg   <= brf_pkg::DATA_WIDTH'(push_word);
            s1_reader_reg <= reader_id;
        end
    end

    brf_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op_en       (s1_go),
        .op_func     (s1_func_reg),
        .op_word     (s1_word_reg),
        .op_reader   (s1_reader_reg),
        .rd_data     (rd_data),
        .wr          (wr),
        .rd_addr     (rd_addr),
        .res_status  (res_status),
        .res_head    (res_head),
        .res_occ     (res_occ)
    );

    brf_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result register
    assign out_valid_next = s1_go || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            status_reg <= res_status;
            head_reg   <= res_head;
            occ_reg    <= res_occ;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign head_word = head_reg;
    assign occupancy = occ_reg;

endmodule

### sv/brf_checker.sv
// port-level checks of the broadcast ring fifo, bound to the top level
module brf_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [brf_pkg::STATUS_W-1:0]       status,
    input logic [brf_pkg::WORD_W-1:0]         head_word,
    input logic [brf_pkg::OCC_W-1:0]          occupancy
);

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(head_word) && $stable(occupancy))
        else $error("stalled result changed");

    // input stall only comes from a full, stalled output side
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // an empty read leaves nothing in the ring and returns no word
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == brf_pkg::ST_EMPTY |-> occupancy == '0 && head_word == '0)
        else $error("empty result with data or occupancy");

    // a push never returns a head word and a stored push leaves the ring non-empty
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == brf_pkg::ST_PUSHED |-> occupancy != '0 && head_word == '0)
        else $error("push result inconsistent");

endmodule

bind broadcast_ring_fifo brf_checker u_brf_checker (.*);
